### src/vpfd_pkg.sv
// Shared types, constants and the microcode table of the velocity PID unit.
// Used by the top level; depends on nothing else.
package vpfd_pkg;

	localparam int FRAC_W  = 16;
	localparam int GAIN_W  = 24;
	localparam int LIM_W   = 15;
	localparam int ALPHA_W = 17;
	localparam int SPD_W   = 16;
	localparam int DIFF_W  = 17;
	localparam int PROD_W  = 50;
	localparam int PTERM_W = 40;
	localparam int INTEG_W = 32;
	localparam int DRAW_W  = 41;
	localparam int DERIV_W = 48;
	localparam int ACC_W   = 66;
	localparam int SUM_W   = 50;
	localparam int HALF_W  = 24;
	localparam int OPND_W  = 25;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	typedef logic [3:0] step_t;

	localparam step_t STEP_FIRST = 4'd0;
	localparam step_t STEP_OFF   = 4'd10;

	typedef enum logic [2:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_INTEG_GAIN     = 3'd1,
		REG_DERIV_GAIN     = 3'd2,
		REG_INTEGRAL_LIMIT = 3'd3,
		REG_OUTPUT_LIMIT   = 3'd4,
		REG_DERIV_ALPHA    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		A_PROP,
		A_INTEG,
		A_DGAIN,
		A_ALPHA,
		A_OMA
	} asel_t;

	typedef enum logic [2:0] {
		B_ERR,
		B_DIFF,
		B_PLO,
		B_PHI,
		B_DLO,
		B_DHI
	} bsel_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LD_P,
		OP_UPD_I,
		OP_LD_DR,
		OP_LD_ACC,
		OP_ADD,
		OP_ADD_SH,
		OP_FIN_D,
		OP_OUT,
		OP_OFF
	} op_t;

	typedef enum logic {
		JMP_NONE,
		JMP_IF_OFF
	} jmp_t;

	typedef struct packed {
		asel_t asel;
		bsel_t bsel;
		op_t   op;
		jmp_t  jmp;
		step_t target;
		logic  done;
	} ctrl_word_t;

	// Each step launches one multiply; steps 1 to 7 consume the product launched one step earlier.
	function automatic ctrl_word_t ucode(step_t s);
		ctrl_word_t w;
		w = '{asel: A_PROP, bsel: B_ERR, op: OP_NOP, jmp: JMP_NONE,
			target: STEP_FIRST, done: 1'b0};
		unique case (s)
			4'd0: begin
				w.jmp    = JMP_IF_OFF;
				w.target = STEP_OFF;
			end
			4'd1: begin
				w.asel = A_INTEG;
				w.op   = OP_LD_P;
			end
			4'd2: begin
				w.asel = A_DGAIN;
				w.bsel = B_DIFF;
				w.op   = OP_UPD_I;
			end
			4'd3: begin
				w.asel = A_OMA;
				w.bsel = B_PLO;
				w.op   = OP_LD_DR;
			end
			4'd4: begin
				w.asel = A_OMA;
				w.bsel = B_PHI;
				w.op   = OP_LD_ACC;
			end
			4'd5: begin
				w.asel = A_ALPHA;
				w.bsel = B_DLO;
				w.op   = OP_ADD_SH;
			end
			4'd6: begin
				w.asel = A_ALPHA;
				w.bsel = B_DHI;
				w.op   = OP_ADD;
			end
			4'd7: begin
				w.op = OP_ADD_SH;
			end
			4'd8: begin
				w.op = OP_FIN_D;
			end
			4'd9: begin
				w.op   = OP_OUT;
				w.done = 1'b1;
			end
			4'd10: begin
				w.op   = OP_OFF;
				w.done = 1'b1;
			end
			default: begin
				w.done = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

### src/vpfd_in_if.sv
// Input channel of the velocity PID unit: one control tick per item.
// Standalone; no package dependency.
interface vpfd_in_if;
	logic               valid;
	logic               ready;
	logic               enable;
	logic signed [15:0] target_speed;
	logic signed [15:0] measured_speed;

	modport source(output valid, enable, target_speed, measured_speed, input ready);
	modport sink(input valid, enable, target_speed, measured_speed, output ready);
endinterface

### src/vpfd_out_if.sv
// Output channel of the velocity PID unit: one drive current per item.
// Standalone; no package dependency.
interface vpfd_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive_current;

	modport source(output valid, drive_current, input ready);
	modport sink(input valid, drive_current, output ready);
endinterface

### src/velocity_pid_filtered_derivative_unit.sv
// An enabled item runs the whole microcode program, which sends all seven products through
// the single 25x25 multiplier; a disabled item jumps from the first step to the step that
// outputs zero. The input is taken again only after the final step of the program, so the
// unit cannot take a new item before it is through with the last one.
// A new item is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the integral, previous error and derivative,
// and loads the register defaults.
module velocity_pid_filtered_derivative_unit (
	input  logic        clk,
	input  logic        arst_n,
	vpfd_in_if.sink     req,
	vpfd_out_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import vpfd_pkg::*;

	logic [GAIN_W-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [LIM_W-1:0]   integral_limit_q, output_limit_q;
	logic [ALPHA_W-1:0] deriv_alpha_q;

	logic signed [INTEG_W-1:0] integ_acc_q;
	logic signed [SPD_W-1:0]   prev_error_q;
	logic signed [DERIV_W-1:0] prev_deriv_q;

	logic                      busy_q, en_q, out_valid_q;
	step_t                     step_q;
	logic signed [SPD_W-1:0]   err_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PTERM_W-1:0] p_q;
	logic signed [DRAW_W-1:0]  dr_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SPD_W-1:0]   result_q;

	ctrl_word_t                cw;
	logic                      accept, slot_free, fire, cfg_wr;
	reg_idx_t                  widx;
	logic signed [SPD_W-1:0]   err_in;
	logic signed [DIFF_W-1:0]  diff_in;
	logic [ALPHA_W-1:0]        alpha_eff, oma;
	logic signed [OPND_W-1:0]  a_op, b_op;
	logic signed [PROD_W-1:0]  prod_d;
	logic signed [ACC_W-1:0]   prod_ext;
	logic signed [INTEG_W+9:0] isum, ilim;
	logic signed [INTEG_W-1:0] integ_d;
	logic signed [DERIV_W-1:0] d_out;
	logic signed [SUM_W-1:0]   olim, clamped, rounded;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= '0;
			integ_gain_q     <= '0;
			deriv_gain_q     <= '0;
			integral_limit_q <= LIM_W'(500);
			output_limit_q   <= LIM_W'(500);
			deriv_alpha_q    <= ALPHA_ONE;
		end else if (cfg_wr) begin
			unique case (widx)
				REG_PROP_GAIN:      prop_gain_q      <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:     integ_gain_q     <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:     deriv_gain_q     <= pwdata[GAIN_W-1:0];
				REG_INTEGRAL_LIMIT: integral_limit_q <= pwdata[LIM_W-1:0];
				REG_OUTPUT_LIMIT:   output_limit_q   <= pwdata[LIM_W-1:0];
				REG_DERIV_ALPHA:    deriv_alpha_q    <= pwdata[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			REG_PROP_GAIN:      prdata = 32'(prop_gain_q);
			REG_INTEG_GAIN:     prdata = 32'(integ_gain_q);
			REG_DERIV_GAIN:     prdata = 32'(deriv_gain_q);
			REG_INTEGRAL_LIMIT: prdata = 32'(integral_limit_q);
			REG_OUTPUT_LIMIT:   prdata = 32'(output_limit_q);
			REG_DERIV_ALPHA:    prdata = 32'(deriv_alpha_q);
			default:            prdata = '0;
		endcase
	end

	// ---------------- sequencer control ----------------
	assign req.ready = !busy_q;
	assign accept    = req.valid && !busy_q;
	assign cw        = ucode(step_q);
	assign slot_free = !out_valid_q || rsp.ready;
	// A final step waits until the output register can take its result.
	assign fire      = busy_q && (!cw.done || slot_free);

	assign rsp.valid         = out_valid_q;
	assign rsp.drive_current = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (fire && cw.done) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= STEP_FIRST;
			end else if (fire) begin
				if (cw.done) begin
					busy_q <= 1'b0;
				end else if (cw.jmp == JMP_IF_OFF && !en_q) begin
					step_q <= cw.target;
				end else begin
					step_q <= step_q + step_t'(1);
				end
			end
		end
	end

	// ---------------- datapath ----------------
	assign err_in  = req.target_speed - req.measured_speed;
	assign diff_in = DIFF_W'(err_in) - DIFF_W'(prev_error_q);

	assign alpha_eff = deriv_alpha_q[ALPHA_W-1] ? ALPHA_ONE : {1'b0, deriv_alpha_q[FRAC_W-1:0]};
	assign oma       = ALPHA_ONE - alpha_eff;

	always_comb begin
		case (cw.asel)
			A_PROP:  a_op = $signed({1'b0, prop_gain_q});
			A_INTEG: a_op = $signed({1'b0, integ_gain_q});
			A_DGAIN: a_op = $signed({1'b0, deriv_gain_q});
			A_ALPHA: a_op = $signed(OPND_W'(alpha_eff));
			A_OMA:   a_op = $signed(OPND_W'(oma));
			default: a_op = '0;
		endcase
		case (cw.bsel)
			B_ERR:   b_op = OPND_W'(err_q);
			B_DIFF:  b_op = OPND_W'(diff_q);
			B_PLO:   b_op = $signed({1'b0, prev_deriv_q[HALF_W-1:0]});
			B_PHI:   b_op = OPND_W'($signed(prev_deriv_q[DERIV_W-1:HALF_W]));
			B_DLO:   b_op = $signed({1'b0, dr_q[HALF_W-1:0]});
			B_DHI:   b_op = OPND_W'($signed(dr_q[DRAW_W-1:HALF_W]));
			default: b_op = '0;
		endcase
	end

	assign prod_d   = PROD_W'(a_op) * PROD_W'(b_op);
	assign prod_ext = ACC_W'(prod_q);

	// Integral update with symmetric clamp.
	assign isum = (INTEG_W+10)'(integ_acc_q) + (INTEG_W+10)'($signed(prod_q[DRAW_W-1:0]));
	assign ilim = $signed({11'b0, integral_limit_q, 16'b0});
	always_comb begin
		if (isum > ilim) begin
			integ_d = INTEG_W'(ilim);
		end else if (isum < -ilim) begin
			integ_d = INTEG_W'(-ilim);
		end else begin
			integ_d = INTEG_W'(isum);
		end
	end

	// Arithmetic shift of the blend gives the floor division by 2^16.
	assign d_out = acc_q[DERIV_W+FRAC_W-1:FRAC_W];

	assign olim = $signed({19'b0, output_limit_q, 16'b0});
	always_comb begin
		if (sum_q > olim) begin
			clamped = olim;
		end else if (sum_q < -olim) begin
			clamped = -olim;
		end else begin
			clamped = sum_q;
		end
		// Negative values get a bias so the shift truncates toward zero.
		rounded = clamped[SUM_W-1] ? clamped + SUM_W'(65535) : clamped;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			en_q   <= req.enable;
			err_q  <= err_in;
			diff_q <= diff_in;
		end
		if (busy_q) begin
			prod_q <= prod_d;
		end
		if (fire) begin
			case (cw.op)
				OP_LD_P:   p_q   <= prod_q[PTERM_W-1:0];
				OP_LD_DR:  dr_q  <= prod_q[DRAW_W-1:0];
				OP_LD_ACC: acc_q <= prod_ext;
				OP_ADD:    acc_q <= acc_q + prod_ext;
				OP_ADD_SH: acc_q <= acc_q + {prod_ext[ACC_W-HALF_W-1:0], {HALF_W{1'b0}}};
				OP_FIN_D:  sum_q <= SUM_W'(p_q) + SUM_W'(integ_acc_q) + SUM_W'(d_out);
				OP_OUT:    result_q <= rounded[FRAC_W+SPD_W-1:FRAC_W];
				OP_OFF:    result_q <= '0;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_acc_q  <= '0;
			prev_error_q <= '0;
			prev_deriv_q <= '0;
		end else if (fire) begin
			case (cw.op)
				OP_UPD_I: integ_acc_q <= integ_d;
				OP_FIN_D: begin
					prev_error_q <= err_q;
					prev_deriv_q <= d_out;
				end
				OP_OFF:   integ_acc_q <= '0;
				default: ;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> busy_q && step_q == STEP_FIRST)
		else $error("accepted item did not start the program at its first step");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> step_q <= STEP_OFF)
		else $error("step counter left the microcode program");

	a_out_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ($signed(rsp.drive_current) <= $signed({1'b0, output_limit_q})
			&& $signed(rsp.drive_current) >= -$signed({1'b0, output_limit_q})))
		else $error("drive current exceeds the output limit");

	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && step_q == STEP_OFF && slot_free |=> rsp.valid && rsp.drive_current == '0)
		else $error("disabled item produced a nonzero drive current");

endmodule

### tb/sv/velocity_pid_filtered_derivative_checker.sv
// Scoreboard for the velocity PID unit: snoops the register port and both item
// channels, predicts every drive current and compares results in order.
// Depends on vpfd_pkg and the vpfd_in_if / vpfd_out_if channel interfaces.
module velocity_pid_filtered_derivative_checker (
	input  logic        clk,
	input  logic        arst_n,
	vpfd_in_if          req,
	vpfd_out_if         rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          mismatches,
	output int          outstanding
);
	import vpfd_pkg::*;

	localparam longint UNITY = longint'(ALPHA_ONE);

	// Register copies, held as plain signed 64-bit numbers for the arithmetic.
	longint prop_gain;
	longint integ_gain;
	longint deriv_gain;
	longint integ_limit;
	longint out_limit;
	longint deriv_alpha;

	// Controller state, 16 fraction bits where it applies.
	longint integ_acc;
	longint last_error;
	longint last_deriv;

	logic signed [15:0] drive_current_q[$];
	int                 fail_count;

	function automatic longint saturate(longint x, longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	function automatic logic signed [15:0] predict_drive_current(logic en,
			logic signed [15:0] tgt, logic signed [15:0] meas);
		logic signed [15:0] err16;
		longint err;
		longint p_term;
		longint d_raw;
		longint d_out;
		longint alpha;
		longint total;
		if (!en) begin
			// A disabled tick drops the integral but keeps the derivative history.
			integ_acc = 0;
			return '0;
		end
		err16 = tgt - meas;
		err = longint'(err16);
		p_term = prop_gain * err;
		integ_acc = saturate(integ_acc + integ_gain * err, integ_limit <<< FRAC_W);
		alpha = (deriv_alpha > UNITY) ? UNITY : deriv_alpha;
		d_raw = deriv_gain * (err - last_error);
		// Arithmetic shift of the blend rounds toward minus infinity.
		d_out = (alpha * d_raw + (UNITY - alpha) * last_deriv) >>> FRAC_W;
		last_error = err;
		last_deriv = d_out;
		total = saturate(p_term + integ_acc + d_out, out_limit <<< FRAC_W);
		if (total < 0)
			total = -((-total) >>> FRAC_W);
		else
			total = total >>> FRAC_W;
		return total[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			prop_gain   = 0;
			integ_gain  = 0;
			deriv_gain  = 0;
			integ_limit = 500;
			out_limit   = 500;
			deriv_alpha = UNITY;
			integ_acc   = 0;
			last_error  = 0;
			last_deriv  = 0;
			drive_current_q.delete();
			fail_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[4:2]))
				REG_PROP_GAIN:      prop_gain   = longint'(pwdata[GAIN_W-1:0]);
				REG_INTEG_GAIN:     integ_gain  = longint'(pwdata[GAIN_W-1:0]);
				REG_DERIV_GAIN:     deriv_gain  = longint'(pwdata[GAIN_W-1:0]);
				REG_INTEGRAL_LIMIT: integ_limit = longint'(pwdata[LIM_W-1:0]);
				REG_OUTPUT_LIMIT:   out_limit   = longint'(pwdata[LIM_W-1:0]);
				REG_DERIV_ALPHA:    deriv_alpha = longint'(pwdata[ALPHA_W-1:0]);
				default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (drive_current_q.size() == 0) begin
					$error("drive_current: unexpected result %0d", rsp.drive_current);
					fail_count++;
				end else begin
					want = drive_current_q.pop_front();
					if (rsp.drive_current !== want) begin
						$error("drive_current: expected %0d, actual %0d", want,
							rsp.drive_current);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				drive_current_q.push_back(predict_drive_current(req.enable,
					req.target_speed, req.measured_speed));
			mismatches  <= fail_count;
			outstanding <= drive_current_q.size();
		end
	end

endmodule

### tb/sv/velocity_pid_filtered_derivative_unit_test.sv
// Top of the velocity PID unit bench: clock, reset, register writes, tick
// stimulus with bursty sending and a stalling receiver, watchdog and verdict.
// Depends on vpfd_pkg, the channel interfaces, the unit and its checker.
module velocity_pid_filtered_derivative_unit_test;
	import vpfd_pkg::*;

	localparam int PHASES          = 7;
	localparam int TICKS_PER_PHASE = 100;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 20;

	// Addresses past the last register; writes there must change nothing.
	localparam logic [4:0] SPARE_ADDR_LO = 5'd24;
	localparam logic [4:0] SPARE_ADDR_HI = 5'd28;

	localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
	localparam logic signed [15:0] SPEED_MIN = 16'sh8000;

	typedef enum int {
		RX_FREE,
		RX_HALF,
		RX_SPARSE
	} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic        pready;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	int          mismatches;
	int          outstanding;
	int          burst_left;
	// Number of long hold-offs asked of the receiver so far.
	int          hold_off_request;

	vpfd_in_if  req_ch();
	vpfd_out_if rsp_ch();

	velocity_pid_filtered_derivative_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	velocity_pid_filtered_derivative_checker current_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_register(input logic [4:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] p, input logic [31:0] i,
			input logic [31:0] d, input logic [31:0] ilim, input logic [31:0] olim,
			input logic [31:0] alpha);
		write_register({REG_PROP_GAIN, 2'b00}, p);
		write_register({REG_INTEG_GAIN, 2'b00}, i);
		write_register({REG_DERIV_GAIN, 2'b00}, d);
		write_register({REG_INTEGRAL_LIMIT, 2'b00}, ilim);
		write_register({REG_OUTPUT_LIMIT, 2'b00}, olim);
		write_register({REG_DERIV_ALPHA, 2'b00}, alpha);
	endtask

	// Random settings; the bits above each register's width carry junk.
	task automatic shuffle_settings();
		logic [31:0] v[6];
		for (int k = 0; k < 6; k++)
			v[k] = $urandom;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 3))
			0: v[k][GAIN_W-1:0] = '0;
			1: v[k][GAIN_W-1:0] = '1;
			2: ;
			default: v[k][GAIN_W-1:0] = GAIN_W'($urandom_range(0, 'h30000));
			endcase
		end
		for (int k = 3; k < 5; k++) begin
			case ($urandom_range(0, 4))
			0: v[k][LIM_W-1:0] = '0;
			1: v[k][LIM_W-1:0] = '1;
			2: v[k][LIM_W-1:0] = 15'd16384;
			3: ;
			default: v[k][LIM_W-1:0] = LIM_W'($urandom_range(0, 2000));
			endcase
		end
		case ($urandom_range(0, 4))
		0: v[5][ALPHA_W-1:0] = '0;
		1: v[5][ALPHA_W-1:0] = ALPHA_ONE;
		2: v[5][ALPHA_W-1:0] = '1;
		3: ;
		default: v[5][ALPHA_W-1:0] = ALPHA_W'($urandom_range(0, 65536));
		endcase
		load_settings(v[0], v[1], v[2], v[3], v[4], v[5]);
		if ($urandom_range(0, 2) == 0)
			write_register($urandom_range(0, 1) ? SPARE_ADDR_HI : SPARE_ADDR_LO, $urandom);
	endtask

	// Offers one tick and waits for the edge that accepts it; the sender then
	// pauses for a random gap whenever its current burst runs out.
	task automatic offer_tick(input logic en, input logic signed [15:0] tgt,
			input logic signed [15:0] meas);
		req_ch.valid          <= 1'b1;
		req_ch.enable         <= en;
		req_ch.target_speed   <= tgt;
		req_ch.measured_speed <= meas;
		do @(posedge clk); while (!req_ch.ready);
		burst_left--;
		if (burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		logic signed [15:0] setpoint;
		logic signed [15:0] tgt;
		logic signed [15:0] meas;
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.enable         <= 1'b0;
		req_ch.target_speed   <= '0;
		req_ch.measured_speed <= '0;
		hold_off_request = 0;
		burst_left = $urandom_range(1, 40);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset gains are zero, so the first output is zero too.
		offer_tick(1'b1, 16'sd1234, 16'sd0);
		settle();

		load_settings(32'h0001_0000, 32'h0000_4000, 32'h0000_8000, 32'd100, 32'd16384,
			32'h0001_0000);
		offer_tick(1'b0, 16'sd0, 16'sd0);
		offer_tick(1'b1, SPEED_MAX, SPEED_MIN);
		offer_tick(1'b1, SPEED_MIN, SPEED_MAX);
		offer_tick(1'b1, SPEED_MAX, 16'sd0);
		// The error swings from the top to the bottom of its range in one tick.
		offer_tick(1'b1, SPEED_MIN, 16'sd0);
		offer_tick(1'b1, SPEED_MIN, 16'sd0);
		offer_tick(1'b0, 16'sd100, 16'sd0);
		offer_tick(1'b1, 16'sd100, 16'sd0);
		offer_tick(1'b1, 16'sd0, 16'sd0);
		settle();

		// Zero limits, alpha above one.
		load_settings(32'h0001_0000, 32'h0000_4000, 32'h0001_0000, 32'd0, 32'd0,
			32'h0001_FFFF);
		offer_tick(1'b1, 16'sd1000, -16'sd1000);
		offer_tick(1'b1, -16'sd1000, 16'sd1000);
		offer_tick(1'b1, 16'sd0, 16'sd0);
		settle();

		// Gains and limits written with all ones, so they sit at their top; alpha at one half.
		load_settings('1, '1, '1, '1, '1, 32'h0000_8000);
		write_register(SPARE_ADDR_LO, '1);
		write_register(SPARE_ADDR_HI, '0);
		offer_tick(1'b1, SPEED_MAX, -16'sd1);
		offer_tick(1'b1, SPEED_MAX, 16'sd0);
		offer_tick(1'b1, SPEED_MIN, 16'sd1);
		offer_tick(1'b1, -16'sd1, 16'sd0);
		offer_tick(1'b1, 16'sd1, 16'sd0);
		settle();

		// The integral sits above the new, lower limit until the next enabled tick.
		load_settings(32'h0000_0100, 32'h0002_0000, 32'h0000_0001, 32'd16384, 32'd16384,
			32'd0);
		offer_tick(1'b1, 16'sd3000, 16'sd0);
		offer_tick(1'b1, 16'sd3000, 16'sd0);
		settle();
		write_register({REG_INTEGRAL_LIMIT, 2'b00}, 32'd10);
		offer_tick(1'b1, -16'sd3000, 16'sd0);
		offer_tick(1'b1, -16'sd5, 16'sd0);
		offer_tick(1'b0, 16'sd0, 16'sd0);
		offer_tick(1'b1, 16'sd7, -16'sd7);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			shuffle_settings();
			setpoint = 16'($urandom);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (n == 30 && (ph == 2 || ph == 5))
					hold_off_request++;
				if ($urandom_range(0, 24) == 0)
					setpoint = 16'($urandom);
				tgt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : setpoint;
				// Mostly the loop tracks its target closely; sometimes feedback jumps.
				if ($urandom_range(0, 3) == 0)
					meas = 16'($urandom);
				else
					meas = tgt + 16'($urandom_range(0, 600)) - 16'sd300;
				offer_tick($urandom_range(0, 11) != 0, tgt, meas);
			end
		end
		settle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver: segments of free, half-rate or sparse acceptance, plus a long
	// hold-off on request that lets the unit fill up and stall its input.
	initial begin
		rx_mode_t mode;
		int       span;
		int       hold_offs_served;
		hold_offs_served = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 2));
			span = $urandom_range(10, 150);
			repeat (span) begin
				@(posedge clk);
				if (hold_offs_served != hold_off_request) begin
					rsp_ch.ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					hold_offs_served++;
				end
				case (mode)
				RX_FREE: rsp_ch.ready <= 1'b1;
				RX_HALF: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
					|| (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
src/vpfd_pkg.sv
src/vpfd_in_if.sv
src/vpfd_out_if.sv
src/velocity_pid_filtered_derivative_unit.sv
tb/sv/velocity_pid_filtered_derivative_checker.sv
tb/sv/velocity_pid_filtered_derivative_unit_test.sv
